// File: hw/rtl/variable_record_ring_allocator_assert.svh
// Assertion macros used by the checker of the record ring allocator.
`ifndef VARIABLE_RECORD_RING_ALLOCATOR_ASSERT_SVH
`define VARIABLE_RECORD_RING_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, sampled on clock and disabled during reset.
`define VRRA_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and disabled during reset.
`define VRRA_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/vrra_pkg.sv
// Types, constants and slot arithmetic of the record ring allocator.
`default_nettype none

package vrra_pkg;

   localparam int REGION_BYTES = 524288;
   localparam int MAX_RECORDS  = 256;
   localparam int SLOT_W       = $clog2(MAX_RECORDS);
   localparam int CNT_W        = $clog2(MAX_RECORDS + 1);

   localparam int BYTES_W  = 20;
   localparam int OFFSET_W = 19;
   localparam int AGE_W    = 8;
   localparam int COUNT_W  = 9;
   localparam int END_W    = OFFSET_W + 2;

   localparam logic [BYTES_W-1:0] USABLE_RESET = 20'h80000;

   typedef enum logic {
      CMD_ALLOC  = 1'b0,
      CMD_LOOKUP = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_TOO_BIG   = 2'd1,
      ST_NOT_FOUND = 2'd2
   } status_type;

   typedef struct packed {
      cmd_type             cmd;
      logic [BYTES_W-1:0]  record_bytes;
      logic [AGE_W-1:0]    age_index;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [OFFSET_W-1:0] record_offset;
      logic [BYTES_W-1:0]  record_size;
      logic [COUNT_W-1:0]  evicted_count;
      logic [COUNT_W-1:0]  stored_count;
   } rsp_type;

   typedef struct packed {
      logic [OFFSET_W-1:0] start;
      logic [BYTES_W-1:0]  length;
   } entry_type;

   typedef struct packed {
      logic              wr_en;
      logic [SLOT_W-1:0] wr_addr;
      entry_type         wr_data;
      logic [SLOT_W-1:0] rd_addr;
   } mem_req_type;

   // Slot s advanced by k places around the descriptor ring, k at most MAX_RECORDS.
   function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] s,
                                                  input logic [CNT_W-1:0] k);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(s) + (CNT_W+1)'(k);
      if (sum >= (CNT_W+1)'(MAX_RECORDS)) begin
         sum = sum - (CNT_W+1)'(MAX_RECORDS);
      end
      return SLOT_W'(sum);
   endfunction

   // Slot s moved back by d places, d from 1 to MAX_RECORDS.
   function automatic logic [SLOT_W-1:0] slot_back(input logic [SLOT_W-1:0] s,
                                                   input logic [CNT_W-1:0] d);
      return slot_add(s, CNT_W'(MAX_RECORDS) - d);
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/vrra_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module vrra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/vrra_ctrl.sv
// Sequencer that reads, checks and updates the descriptor ring for each request.
`default_nettype none

module vrra_ctrl (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [vrra_pkg::BYTES_W-1:0] usable,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire vrra_pkg::req_type            req_data,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output vrra_pkg::rsp_type                 rsp_data,
   output vrra_pkg::mem_req_type             mem_req,
   input  wire vrra_pkg::entry_type          mem_rdata
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOOK_RD,
      S_NEW_RD,
      S_PLACE,
      S_SCAN,
      S_COMMIT,
      S_DONE
   } state_type;

   state_type                         state_ff, state_in;
   logic [vrra_pkg::BYTES_W-1:0]      need_ff, need_in;
   logic [vrra_pkg::BYTES_W-1:0]      limit_ff, limit_in;
   logic [vrra_pkg::END_W-1:0]        end_ff, end_in;
   logic [vrra_pkg::END_W-1:0]        span_end_ff, span_end_in;
   logic [vrra_pkg::OFFSET_W-1:0]     cand_ff, cand_in;
   logic [vrra_pkg::SLOT_W-1:0]       oldest_ff, oldest_in;
   logic [vrra_pkg::SLOT_W-1:0]       next_ff, next_in;
   logic [vrra_pkg::CNT_W-1:0]        held_ff, held_in;
   logic [vrra_pkg::CNT_W-1:0]        scan_idx_ff, scan_idx_in;
   logic                              rd_valid_ff, rd_valid_in;
   logic [vrra_pkg::CNT_W-1:0]        rd_idx_ff, rd_idx_in;
   logic [vrra_pkg::CNT_W-1:0]        hits_ff, hits_in;
   vrra_pkg::rsp_type                 res_ff, res_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   vrra_pkg::rsp_type                 rsp_data_ff, rsp_data_in;

   logic [vrra_pkg::BYTES_W-1:0] limit_now;
   logic [vrra_pkg::CNT_W-1:0]   evict;
   logic [vrra_pkg::CNT_W-1:0]   held_after;
   logic                         hit;

   always_comb begin
      if (32'(usable) < 32'(vrra_pkg::REGION_BYTES)) begin
         limit_now = usable;
      end else begin
         limit_now = vrra_pkg::BYTES_W'(vrra_pkg::REGION_BYTES);
      end
   end

   assign hit = rd_valid_ff
             && (vrra_pkg::END_W'(mem_rdata.start) < span_end_ff)
             && (vrra_pkg::END_W'(cand_ff)
                 < vrra_pkg::END_W'(mem_rdata.start) + vrra_pkg::END_W'(mem_rdata.length));

   // A full ring with nothing overlapping still loses its oldest record.
   assign evict = hits_ff + vrra_pkg::CNT_W'(hits_ff == '0
                  && held_ff == vrra_pkg::CNT_W'(vrra_pkg::MAX_RECORDS));
   assign held_after = held_ff - evict + vrra_pkg::CNT_W'(1);

   always_comb begin
      state_in     = state_ff;
      need_in      = need_ff;
      limit_in     = limit_ff;
      end_in       = end_ff;
      span_end_in  = span_end_ff;
      cand_in      = cand_ff;
      oldest_in    = oldest_ff;
      next_in      = next_ff;
      held_in      = held_ff;
      scan_idx_in  = scan_idx_ff;
      rd_valid_in  = 1'b0;
      rd_idx_in    = rd_idx_ff;
      hits_in      = hits_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mem_req      = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               need_in     = req_data.record_bytes;
               limit_in    = limit_now;
               cand_in     = '0;
               span_end_in = vrra_pkg::END_W'(req_data.record_bytes);
               scan_idx_in = '0;
               hits_in     = '0;
               res_in      = '0;
               res_in.stored_count = vrra_pkg::COUNT_W'(held_ff);
               if (req_data.cmd == vrra_pkg::CMD_LOOKUP) begin
                  if (32'(req_data.age_index) < 32'(held_ff)) begin
                     mem_req.rd_addr = vrra_pkg::slot_back(next_ff,
                        vrra_pkg::CNT_W'(req_data.age_index) + vrra_pkg::CNT_W'(1));
                     state_in = S_LOOK_RD;
                  end else begin
                     res_in.status = vrra_pkg::ST_NOT_FOUND;
                     state_in      = S_DONE;
                  end
               end else if (req_data.record_bytes == '0
                            || req_data.record_bytes > limit_now) begin
                  res_in.status = vrra_pkg::ST_TOO_BIG;
                  state_in      = S_DONE;
               end else if (held_ff == '0) begin
                  state_in = S_COMMIT;
               end else begin
                  mem_req.rd_addr = vrra_pkg::slot_back(next_ff, vrra_pkg::CNT_W'(1));
                  state_in        = S_NEW_RD;
               end
            end
         end
         S_LOOK_RD: begin
            res_in.status        = vrra_pkg::ST_OK;
            res_in.record_offset = mem_rdata.start;
            res_in.record_size   = mem_rdata.length;
            state_in             = S_DONE;
         end
         S_NEW_RD: begin
            end_in   = vrra_pkg::END_W'(mem_rdata.start) + vrra_pkg::END_W'(mem_rdata.length);
            state_in = S_PLACE;
         end
         S_PLACE: begin
            if ((vrra_pkg::END_W+1)'(end_ff) + (vrra_pkg::END_W+1)'(need_ff)
                <= (vrra_pkg::END_W+1)'(limit_ff)) begin
               cand_in     = vrra_pkg::OFFSET_W'(end_ff);
               span_end_in = end_ff + vrra_pkg::END_W'(need_ff);
            end else begin
               cand_in     = '0;
               span_end_in = vrra_pkg::END_W'(need_ff);
            end
            state_in = S_SCAN;
         end
         S_SCAN: begin
            // One descriptor read per cycle from the oldest; the last overlap found
            // sets how many of the oldest records go.
            if (scan_idx_ff < held_ff) begin
               mem_req.rd_addr = vrra_pkg::slot_add(oldest_ff, scan_idx_ff);
               rd_valid_in     = 1'b1;
               rd_idx_in       = scan_idx_ff;
               scan_idx_in     = scan_idx_ff + vrra_pkg::CNT_W'(1);
            end
            if (hit) begin
               hits_in = rd_idx_ff + vrra_pkg::CNT_W'(1);
            end
            if (scan_idx_ff == held_ff && !rd_valid_ff) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            mem_req.wr_en          = 1'b1;
            mem_req.wr_addr        = next_ff;
            mem_req.wr_data.start  = cand_ff;
            mem_req.wr_data.length = need_ff;
            oldest_in              = vrra_pkg::slot_add(oldest_ff, evict);
            next_in                = vrra_pkg::slot_add(next_ff, vrra_pkg::CNT_W'(1));
            held_in                = held_after;
            res_in.status          = vrra_pkg::ST_OK;
            res_in.record_offset   = cand_ff;
            res_in.record_size     = need_ff;
            res_in.evicted_count   = vrra_pkg::COUNT_W'(evict);
            res_in.stored_count    = vrra_pkg::COUNT_W'(held_after);
            state_in               = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         oldest_ff    <= '0;
         next_ff      <= '0;
         held_ff      <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         oldest_ff    <= oldest_in;
         next_ff      <= next_in;
         held_ff      <= held_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      need_ff     <= need_in;
      limit_ff    <= limit_in;
      end_ff      <= end_in;
      span_end_ff <= span_end_in;
      cand_ff     <= cand_in;
      scan_idx_ff <= scan_idx_in;
      rd_idx_ff   <= rd_idx_in;
      hits_ff     <= hits_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/variable_record_ring_allocator.sv
// Top level of the variable-length record ring allocator.
//
//   channel   ports                              direction   moves
//   req       req_valid req_ready req_data       in          allocate or lookup request
//   rsp       rsp_valid rsp_ready rsp_data       out         one result per request
//   csr       csr_wr_en csr_wr_data              in          usable region size
//
// A lookup reads its descriptor before the result; a rejected request is answered directly.
// An allocation into an empty ring is committed directly; otherwise it reads the newest record,
// picks a place, then reads the descriptor memory once per held record, oldest first, through
// its single port. The next request can be taken while a result is shown, even if it waits;
// a stalled result then holds the following one back.
// Reset empties the ring at once; descriptor contents are left as they are.
`default_nettype none

module variable_record_ring_allocator (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire vrra_pkg::req_type            req_data,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output vrra_pkg::rsp_type                 rsp_data,
   input  wire logic                         csr_wr_en,
   input  wire logic [vrra_pkg::BYTES_W-1:0] csr_wr_data
);

   logic [vrra_pkg::BYTES_W-1:0] usable_ff, usable_in;
   vrra_pkg::mem_req_type        mem_req;
   logic [$bits(vrra_pkg::entry_type)-1:0] mem_rdata;

   always_comb begin
      usable_in = usable_ff;
      if (csr_wr_en) begin
         usable_in = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         usable_ff <= vrra_pkg::USABLE_RESET;
      end else begin
         usable_ff <= usable_in;
      end
   end

   vrra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .usable    (usable_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .mem_req   (mem_req),
      .mem_rdata (vrra_pkg::entry_type'(mem_rdata))
   );

   vrra_ram #(
      .WIDTH ($bits(vrra_pkg::entry_type)),
      .DEPTH (vrra_pkg::MAX_RECORDS)
   ) u_desc_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_addr (mem_req.rd_addr),
      .rd_data (mem_rdata)
   );

endmodule

`default_nettype wire

// File: hw/rtl/vrra_checker.sv
// Port-level checker for the record ring allocator and its bind to the top level.
`default_nettype none

`include "variable_record_ring_allocator_assert.svh"

module vrra_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire vrra_pkg::rsp_type rsp_data
);

   logic [1:0]                   pending_ff, pending_in;
   logic [vrra_pkg::COUNT_W-1:0] last_stored_ff, last_stored_in;
   logic                         req_xfer, rsp_xfer, rsp_stall;
   logic [vrra_pkg::COUNT_W:0]   count_sum;
   logic                         count_kept, count_grown;

   assign req_xfer    = req_valid && req_ready;
   assign rsp_xfer    = rsp_valid && rsp_ready;
   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign count_sum   = (vrra_pkg::COUNT_W+1)'(rsp_data.stored_count)
                      + (vrra_pkg::COUNT_W+1)'(rsp_data.evicted_count);
   assign count_kept  = count_sum == (vrra_pkg::COUNT_W+1)'(last_stored_ff);
   assign count_grown = (count_sum == (vrra_pkg::COUNT_W+1)'(last_stored_ff)
                                      + (vrra_pkg::COUNT_W+1)'(1))
                      && (rsp_data.status == vrra_pkg::ST_OK);

   always_comb begin
      pending_in     = pending_ff + 2'(req_xfer) - 2'(rsp_xfer);
      last_stored_in = last_stored_ff;
      if (rsp_xfer) begin
         last_stored_in = rsp_data.stored_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff     <= '0;
         last_stored_ff <= '0;
      end else begin
         pending_ff     <= pending_in;
         last_stored_ff <= last_stored_in;
      end
   end

   `VRRA_ASSERT_NXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_data), "result dropped")
   `VRRA_ASSERT_IMP(a_rsp_has_req, rsp_xfer, pending_ff != 2'd0, "result without a request")
   `VRRA_ASSERT_IMP(a_pending_bound, 1'b1, pending_ff <= 2'd2, "too many requests pending")
   `VRRA_ASSERT_IMP(a_count_track, rsp_xfer, count_kept || count_grown, "stored count jumped")

endmodule

bind variable_record_ring_allocator vrra_checker u_vrra_checker (.*);

`default_nettype wire

// File: bench/variable_record_ring_allocator_test.sv
// Self-checking testbench for the variable-length record ring allocator.
module variable_record_ring_allocator_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 4000;

   typedef struct packed {
      vrra_pkg::req_type ask;
      logic              typed;
      vrra_pkg::rsp_type answer;
   } script_row_type;

   typedef struct packed {
      logic [vrra_pkg::BYTES_W-1:0] usable;
      int unsigned                  small_max;
      int unsigned                  big_pct;
      int unsigned                  count;
   } phase_plan_type;

   localparam script_row_type DIRECTED_SCRIPT [20] = '{
      '{'{vrra_pkg::CMD_LOOKUP, 20'd0, 8'd0}, 1'b1,
        '{vrra_pkg::ST_NOT_FOUND, 19'd0, 20'd0, 9'd0, 9'd0}},
      '{'{vrra_pkg::CMD_LOOKUP, 20'hFFFFF, 8'd255}, 1'b1,
        '{vrra_pkg::ST_NOT_FOUND, 19'd0, 20'd0, 9'd0, 9'd0}},
      '{'{vrra_pkg::CMD_ALLOC, 20'd0, 8'hFF}, 1'b1,
        '{vrra_pkg::ST_TOO_BIG, 19'd0, 20'd0, 9'd0, 9'd0}},
      '{'{vrra_pkg::CMD_ALLOC, 20'hFFFFF, 8'd0}, 1'b1,
        '{vrra_pkg::ST_TOO_BIG, 19'd0, 20'd0, 9'd0, 9'd0}},
      '{'{vrra_pkg::CMD_ALLOC, 20'd524289, 8'd0}, 1'b1,
        '{vrra_pkg::ST_TOO_BIG, 19'd0, 20'd0, 9'd0, 9'd0}},
      '{'{vrra_pkg::CMD_ALLOC, 20'd524288, 8'd0}, 1'b1,
        '{vrra_pkg::ST_OK, 19'd0, 20'd524288, 9'd0, 9'd1}},
      '{'{vrra_pkg::CMD_LOOKUP, 20'd0, 8'd0}, 1'b1,
        '{vrra_pkg::ST_OK, 19'd0, 20'd524288, 9'd0, 9'd1}},
      '{'{vrra_pkg::CMD_LOOKUP, 20'd0, 8'd1}, 1'b1,
        '{vrra_pkg::ST_NOT_FOUND, 19'd0, 20'd0, 9'd0, 9'd1}},
      '{'{vrra_pkg::CMD_ALLOC, 20'd1, 8'd0}, 1'b1,
        '{vrra_pkg::ST_OK, 19'd0, 20'd1, 9'd1, 9'd1}},
      '{'{vrra_pkg::CMD_ALLOC, 20'd100, 8'hAA}, 1'b0, '0},
      '{'{vrra_pkg::CMD_ALLOC, 20'd524187, 8'h55}, 1'b0, '0},
      '{'{vrra_pkg::CMD_LOOKUP, 20'hAAAAA, 8'd0}, 1'b0, '0},
      '{'{vrra_pkg::CMD_LOOKUP, 20'h55555, 8'd2}, 1'b0, '0},
      '{'{vrra_pkg::CMD_LOOKUP, 20'd0, 8'd3}, 1'b0, '0},
      '{'{vrra_pkg::CMD_ALLOC, 20'd1000, 8'd0}, 1'b0, '0},
      '{'{vrra_pkg::CMD_ALLOC, 20'h55555, 8'd0}, 1'b0, '0},
      '{'{vrra_pkg::CMD_ALLOC, 20'hAAAAA, 8'd0}, 1'b0, '0},
      '{'{vrra_pkg::CMD_ALLOC, 20'd524287, 8'd0}, 1'b0, '0},
      '{'{vrra_pkg::CMD_LOOKUP, 20'd0, 8'd0}, 1'b0, '0},
      '{'{vrra_pkg::CMD_LOOKUP, 20'd0, 8'd255}, 1'b0, '0}
   };

   localparam phase_plan_type PHASES [6] = '{
      '{20'h80000, 64, 0, 500},
      '{20'd1, 1, 0, 100},
      '{20'd1000, 100, 10, 300},
      '{20'hFFFFF, 65536, 15, 200},
      '{20'd300000, 40000, 10, 200},
      '{20'h7FFFF, 4096, 5, 300}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   vrra_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   vrra_pkg::rsp_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic [vrra_pkg::BYTES_W-1:0] csr_wr_data = vrra_pkg::USABLE_RESET;

   logic [vrra_pkg::OFFSET_W-1:0] ring_start [vrra_pkg::MAX_RECORDS];
   logic [vrra_pkg::BYTES_W-1:0]  ring_length [vrra_pkg::MAX_RECORDS];
   int unsigned ring_oldest = 0;
   int unsigned ring_next = 0;
   int unsigned ring_held = 0;
   int unsigned usable_limit = 524288;

   vrra_pkg::rsp_type pending_results [$];
   int unsigned failures = 0;
   int unsigned stall_cycles = 0;
   bit req_calm = 1'b0;
   bit rsp_calm = 1'b0;

   variable_record_ring_allocator dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic vrra_pkg::rsp_type ring_result(vrra_pkg::req_type ask);
      vrra_pkg::rsp_type res;
      int unsigned lim, cand, need, slot, s, k, a, l, evicted;
      bit hit;
      res = '0;
      res.status = vrra_pkg::ST_OK;
      evicted = 0;
      if (ask.cmd == vrra_pkg::CMD_LOOKUP) begin
         if (ask.age_index < ring_held) begin
            slot = (ring_next + vrra_pkg::MAX_RECORDS - 1 - ask.age_index)
                   % vrra_pkg::MAX_RECORDS;
            res.record_offset = ring_start[slot];
            res.record_size = ring_length[slot];
         end else begin
            res.status = vrra_pkg::ST_NOT_FOUND;
         end
      end else begin
         lim = (usable_limit < vrra_pkg::REGION_BYTES) ? usable_limit
                                                        : vrra_pkg::REGION_BYTES;
         need = ask.record_bytes;
         if (need == 0 || need > lim) begin
            res.status = vrra_pkg::ST_TOO_BIG;
         end else begin
            cand = 0;
            if (ring_held != 0) begin
               slot = (ring_next + vrra_pkg::MAX_RECORDS - 1) % vrra_pkg::MAX_RECORDS;
               if (ring_start[slot] + ring_length[slot] + need <= lim) begin
                  cand = ring_start[slot] + ring_length[slot];
               end
            end
            hit = 1'b1;
            while (hit) begin
               hit = 1'b0;
               s = ring_oldest;
               for (k = 0; k < ring_held; k++) begin
                  a = ring_start[s];
                  l = ring_length[s];
                  if (a < cand + need && cand < a + l) begin
                     hit = 1'b1;
                  end
                  s = (s + 1) % vrra_pkg::MAX_RECORDS;
               end
               if (hit) begin
                  ring_oldest = (ring_oldest + 1) % vrra_pkg::MAX_RECORDS;
                  ring_held--;
                  evicted++;
               end
            end
            if (ring_held >= vrra_pkg::MAX_RECORDS) begin
               ring_oldest = (ring_oldest + 1) % vrra_pkg::MAX_RECORDS;
               ring_held--;
               evicted++;
            end
            ring_start[ring_next] = vrra_pkg::OFFSET_W'(cand);
            ring_length[ring_next] = vrra_pkg::BYTES_W'(need);
            ring_next = (ring_next + 1) % vrra_pkg::MAX_RECORDS;
            ring_held++;
            res.record_offset = vrra_pkg::OFFSET_W'(cand);
            res.record_size = vrra_pkg::BYTES_W'(need);
            res.evicted_count = vrra_pkg::COUNT_W'(evicted);
         end
      end
      res.stored_count = vrra_pkg::COUNT_W'(ring_held);
      return res;
   endfunction

   task automatic send_request(vrra_pkg::req_type ask, bit typed, vrra_pkg::rsp_type answer);
      int unsigned gap;
      vrra_pkg::rsp_type predicted;
      if ($urandom_range(0, 39) == 0) begin
         req_calm = !req_calm;
      end
      gap = req_calm ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= ask;
      do @(posedge clock); while (req_ready !== 1'b1);
      predicted = ring_result(ask);
      pending_results.push_back(typed ? answer : predicted);
   endtask

   task automatic compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         failures++;
      end
   endtask

   task automatic drain_results();
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("variable_record_ring_allocator_test: FAIL");
            $finish;
         end
      end
   end

   initial begin
      int unsigned stall;
      vrra_pkg::rsp_type want;
      do @(posedge clock); while (reset);
      forever begin
         if ($urandom_range(0, 39) == 0) begin
            rsp_calm = !rsp_calm;
         end
         stall = rsp_calm ? 0 : $urandom_range(0, 7);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         if (pending_results.size() == 0) begin
            $display("%0t: transfer with no result pending, actual %p", $time, rsp_data);
            failures++;
         end else begin
            want = pending_results.pop_front();
            compare_field("status", want.status, rsp_data.status);
            compare_field("record_offset", want.record_offset, rsp_data.record_offset);
            compare_field("record_size", want.record_size, rsp_data.record_size);
            compare_field("evicted_count", want.evicted_count, rsp_data.evicted_count);
            compare_field("stored_count", want.stored_count, rsp_data.stored_count);
         end
      end
   end

   initial begin
      vrra_pkg::req_type ask;
      int unsigned lim, pick, cap;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_SCRIPT[i]) begin
         send_request(DIRECTED_SCRIPT[i].ask, DIRECTED_SCRIPT[i].typed,
                      DIRECTED_SCRIPT[i].answer);
      end
      req_valid <= 1'b0;

      foreach (PHASES[p]) begin
         drain_results();
         repeat (4) @(posedge clock);
         csr_wr_en <= 1'b1;
         csr_wr_data <= PHASES[p].usable;
         @(posedge clock);
         csr_wr_en <= 1'b0;
         usable_limit = PHASES[p].usable;
         lim = (usable_limit < vrra_pkg::REGION_BYTES) ? usable_limit
                                                        : vrra_pkg::REGION_BYTES;
         cap = (PHASES[p].small_max < lim) ? PHASES[p].small_max : lim;
         for (int i = 0; i < PHASES[p].count; i++) begin
            ask.record_bytes = vrra_pkg::BYTES_W'($urandom);
            ask.age_index = vrra_pkg::AGE_W'($urandom);
            if ($urandom_range(0, 99) < 25) begin
               ask.cmd = vrra_pkg::CMD_LOOKUP;
               if (ring_held != 0 && $urandom_range(0, 99) < 85) begin
                  ask.age_index = vrra_pkg::AGE_W'($urandom_range(0, ring_held - 1));
               end
            end else begin
               ask.cmd = vrra_pkg::CMD_ALLOC;
               pick = $urandom_range(0, 99);
               if (pick < 5) begin
                  ask.record_bytes = $urandom_range(0, 1)
                     ? vrra_pkg::BYTES_W'(0)
                     : vrra_pkg::BYTES_W'($urandom_range(lim + 1, 20'hFFFFF));
               end else if (pick < 5 + PHASES[p].big_pct) begin
                  ask.record_bytes = vrra_pkg::BYTES_W'($urandom_range(1, lim));
               end else begin
                  ask.record_bytes = vrra_pkg::BYTES_W'($urandom_range(1, cap));
               end
            end
            send_request(ask, 1'b0, '0);
         end
         req_valid <= 1'b0;
      end

      drain_results();
      repeat (20) @(posedge clock);
      if (failures == 0) begin
         $display("variable_record_ring_allocator_test: PASS");
      end else begin
         $display("variable_record_ring_allocator_test: FAIL");
      end
      $finish;
   end

endmodule
